[hw/rtl/gcomp_pkg.sv]
// ----------------------------------------------------------------------------
// gcomp_pkg
// Shared types, constants and helper functions for the component connector.
// ----------------------------------------------------------------------------
package gcomp_pkg;

    localparam int MAX_NODES = 64;
    localparam int NODE_W    = 7;
    localparam int IDX_W     = $clog2(MAX_NODES);
    localparam int CNT_W     = $clog2(MAX_NODES + 1);
    localparam int ADDC_W    = 6;
    localparam int CFG_AW    = 3;
    localparam int CFG_DW    = 32;

    localparam logic [NODE_W-1:0] NODE_CNT_RST = 7'd64;

    localparam logic REG_NODE_COUNT = 1'b0;
    localparam logic CMD_FINISH     = 1'b1;
    localparam logic KIND_COUNT     = 1'b0;
    localparam logic KIND_EDGE      = 1'b1;

    typedef logic [MAX_NODES-1:0] t_nodes;

    typedef struct packed {
        logic              command;
        logic [NODE_W-1:0] node_a;
        logic [NODE_W-1:0] node_b;
    } t_in_item;

    typedef struct packed {
        logic              record_kind;
        logic [ADDC_W-1:0] added_count;
        logic [NODE_W-1:0] edge_from;
        logic [NODE_W-1:0] edge_to;
        logic              last;
    } t_out_item;

    typedef struct packed {
        logic             we;
        logic             re;
        logic [IDX_W-1:0] addr;
        t_nodes           wmask;
        t_nodes           wdata;
    } t_ram_req;

    function automatic logic [NODE_W-1:0] f_eff_nodes(input logic [NODE_W-1:0] nc);
        logic [NODE_W-1:0] n;
        n = nc;
        if (n == '0) n = NODE_W'(1);
        if (n > NODE_W'(MAX_NODES)) n = NODE_W'(MAX_NODES);
        return n;
    endfunction

    function automatic t_nodes f_node_mask(input logic [NODE_W-1:0] nc);
        t_nodes            m;
        logic [NODE_W-1:0] n;
        n = f_eff_nodes(nc);
        for (int i = 0; i < MAX_NODES; i++) begin
            m[i] = (NODE_W'(i) < n);
        end
        return m;
    endfunction

    function automatic t_nodes f_onehot(input logic [IDX_W-1:0] idx);
        t_nodes m;
        m      = '0;
        m[idx] = 1'b1;
        return m;
    endfunction

endpackage

[hw/rtl/gcomp_ffs.sv]
// ----------------------------------------------------------------------------
// gcomp_ffs
// Find-first-set over a vertex vector, two-level (byte group, then bit).
// ----------------------------------------------------------------------------
module gcomp_ffs (
    input  gcomp_pkg::t_nodes               i_vec,
    output logic                            o_found,
    output logic [gcomp_pkg::IDX_W-1:0]     o_idx
);

    localparam int GRP    = 8;
    localparam int NGRP   = (gcomp_pkg::MAX_NODES + GRP - 1) / GRP;
    localparam int PAD_W  = NGRP * GRP;
    localparam int PIDX_W = $clog2(PAD_W);

    logic [PAD_W-1:0]  padded;
    logic [NGRP-1:0]   grp_any;
    logic [PIDX_W-1:0] grp_base;
    logic [GRP-1:0]    grp_bits;
    logic [2:0]        bit_idx;
    logic [PIDX_W-1:0] full_idx;

    always_comb begin
        padded = PAD_W'(i_vec);
        for (int g = 0; g < NGRP; g++) begin
            grp_any[g] = |padded[g*GRP +: GRP];
        end
        grp_base = '0;
        for (int g = NGRP - 1; g >= 0; g--) begin
            if (grp_any[g]) grp_base = PIDX_W'(g * GRP);
        end
        grp_bits = padded[grp_base +: GRP];
        bit_idx  = '0;
        for (int j = GRP - 1; j >= 0; j--) begin
            if (grp_bits[j]) bit_idx = 3'(j);
        end
        full_idx = grp_base + PIDX_W'(bit_idx);
    end

    assign o_found = |i_vec;
    assign o_idx   = gcomp_pkg::IDX_W'(full_idx);

endmodule

[hw/rtl/gcomp_adj_ram.sv]
// ----------------------------------------------------------------------------
// gcomp_adj_ram
// Adjacency row store, one row per vertex, bit-masked write, registered read.
// ----------------------------------------------------------------------------
module gcomp_adj_ram (
    input  logic                  i_clk,
    input  gcomp_pkg::t_ram_req   i_req,
    output gcomp_pkg::t_nodes     o_rdata
);

    gcomp_pkg::t_nodes r_mem [gcomp_pkg::MAX_NODES];
    gcomp_pkg::t_nodes r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            for (int i = 0; i < gcomp_pkg::MAX_NODES; i++) begin
                if (i_req.wmask[i]) r_mem[i_req.addr][i] <= i_req.wdata[i];
            end
        end
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/gcomp_seq.sv]
// ----------------------------------------------------------------------------
// gcomp_seq
// Sequencer: edge loads, search over the row store, record emission, clear.
// ----------------------------------------------------------------------------
module gcomp_seq (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  gcomp_pkg::t_in_item                i_item,
    input  logic [gcomp_pkg::NODE_W-1:0]       i_node_count,
    output logic                               o_busy,
    output logic                               o_valid,
    output gcomp_pkg::t_out_item               o_res,
    output gcomp_pkg::t_ram_req                o_ram_req,
    input  gcomp_pkg::t_nodes                  i_ram_rdata
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_EDGE2  = 3'd1;
    localparam logic [2:0] S_SEEK   = 3'd2;
    localparam logic [2:0] S_EXPAND = 3'd3;
    localparam logic [2:0] S_WAIT   = 3'd4;
    localparam logic [2:0] S_CNT    = 3'd5;
    localparam logic [2:0] S_EMIT   = 3'd6;
    localparam logic [2:0] S_CLEAR  = 3'd7;

    localparam int IW = gcomp_pkg::IDX_W;
    localparam int NW = gcomp_pkg::NODE_W;

    logic [2:0]                     r_state, n_state;
    gcomp_pkg::t_nodes              r_visited, n_visited;
    gcomp_pkg::t_nodes              r_pending, n_pending;
    gcomp_pkg::t_nodes              r_roots, n_roots;
    gcomp_pkg::t_nodes              r_mask, n_mask;
    logic [gcomp_pkg::CNT_W-1:0]    r_count, n_count;
    logic [IW-1:0]                  r_clr, n_clr;
    logic [IW-1:0]                  r_a_idx, n_a_idx;
    logic [IW-1:0]                  r_b_idx, n_b_idx;
    logic                           r_valid, n_valid;
    gcomp_pkg::t_out_item           r_res, n_res;

    gcomp_pkg::t_nodes              ffs_vec;
    logic                           ffs_found;
    logic [IW-1:0]                  ffs_idx;
    gcomp_pkg::t_nodes              ffs_bit;
    gcomp_pkg::t_nodes              new_nodes;
    gcomp_pkg::t_ram_req            ram_req;
    logic [NW-1:0]                  eff_n;
    logic [NW-1:0]                  a_m1;
    logic [NW-1:0]                  b_m1;
    logic                           edge_ok;
    logic                           accept;

    gcomp_ffs u_ffs (
        .i_vec   (ffs_vec),
        .o_found (ffs_found),
        .o_idx   (ffs_idx)
    );

    assign accept    = i_start && (r_state == S_IDLE);
    assign eff_n     = gcomp_pkg::f_eff_nodes(i_node_count);
    assign a_m1      = i_item.node_a - NW'(1);
    assign b_m1      = i_item.node_b - NW'(1);
    assign edge_ok   = (i_item.node_a != '0) && (i_item.node_a <= eff_n) &&
                       (i_item.node_b != '0) && (i_item.node_b <= eff_n);
    assign ffs_bit   = gcomp_pkg::f_onehot(ffs_idx);
    assign new_nodes = i_ram_rdata & ~r_visited & r_mask;

    always_comb begin
        unique case (r_state)
            S_SEEK:   ffs_vec = ~r_visited & r_mask;
            S_EXPAND: ffs_vec = r_pending;
            S_EMIT:   ffs_vec = r_roots;
            default:  ffs_vec = '0;
        endcase
    end

    always_comb begin
        n_state   = r_state;
        n_visited = r_visited;
        n_pending = r_pending;
        n_roots   = r_roots;
        n_mask    = r_mask;
        n_count   = r_count;
        n_clr     = r_clr;
        n_a_idx   = r_a_idx;
        n_b_idx   = r_b_idx;
        n_valid   = 1'b0;
        n_res     = r_res;
        ram_req   = '0;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_item.command == gcomp_pkg::CMD_FINISH) begin
                        n_visited = '0;
                        n_pending = '0;
                        n_roots   = '0;
                        n_count   = '0;
                        n_mask    = gcomp_pkg::f_node_mask(i_node_count);
                        n_state   = S_SEEK;
                    end else if (edge_ok) begin
                        ram_req.we    = 1'b1;
                        ram_req.addr  = a_m1[IW-1:0];
                        ram_req.wmask = gcomp_pkg::f_onehot(b_m1[IW-1:0]);
                        ram_req.wdata = '1;
                        n_a_idx       = a_m1[IW-1:0];
                        n_b_idx       = b_m1[IW-1:0];
                        n_state       = S_EDGE2;
                    end
                end
            end
            S_EDGE2: begin
                ram_req.we    = 1'b1;
                ram_req.addr  = r_b_idx;
                ram_req.wmask = gcomp_pkg::f_onehot(r_a_idx);
                ram_req.wdata = '1;
                n_state       = S_IDLE;
            end
            S_SEEK: begin
                if (ffs_found) begin
                    n_visited = r_visited | ffs_bit;
                    n_pending = ffs_bit;
                    n_count   = r_count + gcomp_pkg::CNT_W'(1);
                    if (ffs_idx != '0) n_roots = r_roots | ffs_bit;
                    n_state   = S_EXPAND;
                end else begin
                    n_state = S_CNT;
                end
            end
            S_EXPAND: begin
                if (ffs_found) begin
                    ram_req.re   = 1'b1;
                    ram_req.addr = ffs_idx;
                    n_pending    = r_pending & ~ffs_bit;
                    n_state      = S_WAIT;
                end else begin
                    n_state = S_SEEK;
                end
            end
            S_WAIT: begin
                n_visited = r_visited | new_nodes;
                n_pending = r_pending | new_nodes;
                n_state   = S_EXPAND;
            end
            S_CNT: begin
                n_valid           = 1'b1;
                n_res.record_kind = gcomp_pkg::KIND_COUNT;
                n_res.added_count = gcomp_pkg::ADDC_W'(r_count - gcomp_pkg::CNT_W'(1));
                n_res.edge_from   = '0;
                n_res.edge_to     = '0;
                n_res.last        = (r_roots == '0);
                n_clr             = '0;
                n_state           = (r_roots == '0) ? S_CLEAR : S_EMIT;
            end
            S_EMIT: begin
                n_valid           = 1'b1;
                n_res.record_kind = gcomp_pkg::KIND_EDGE;
                n_res.added_count = '0;
                n_res.edge_from   = NW'(1);
                n_res.edge_to     = NW'(ffs_idx) + NW'(1);
                n_roots           = r_roots & ~ffs_bit;
                n_res.last        = (n_roots == '0);
                if (n_roots == '0) n_state = S_CLEAR;
            end
            S_CLEAR: begin
                ram_req.we    = 1'b1;
                ram_req.addr  = r_clr;
                ram_req.wmask = '1;
                ram_req.wdata = '0;
                n_clr         = r_clr + IW'(1);
                if (r_clr == IW'(gcomp_pkg::MAX_NODES - 1)) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr     <= '0;
            r_valid   <= 1'b0;
            r_visited <= '0;
            r_pending <= '0;
            r_roots   <= '0;
            r_mask    <= '0;
            r_count   <= '0;
        end else begin
            r_state   <= n_state;
            r_clr     <= n_clr;
            r_valid   <= n_valid;
            r_visited <= n_visited;
            r_pending <= n_pending;
            r_roots   <= n_roots;
            r_mask    <= n_mask;
            r_count   <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_idx <= n_a_idx;
        r_b_idx <= n_b_idx;
        r_res   <= n_res;
    end

    assign o_busy    = (r_state != S_IDLE);
    assign o_valid   = r_valid;
    assign o_res     = r_res;
    assign o_ram_req = ram_req;

`ifndef SYNTHESIS
    a_visited_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_visited & ~r_mask) == '0)
        else $error("visited vertex outside node range");

    a_pending_visited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pending & ~r_visited) == '0)
        else $error("pending vertex not marked visited");

    a_valid_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> ($past(r_state) == S_CNT || $past(r_state) == S_EMIT))
        else $error("result strobe outside emission");

    a_last_then_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_res.last) |-> (r_state == S_CLEAR))
        else $error("final record not followed by store clear");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= gcomp_pkg::CNT_W'(gcomp_pkg::MAX_NODES))
        else $error("component count overflow");
`endif

endmodule

[hw/rtl/graph_component_connector.sv]
// ----------------------------------------------------------------------------
// graph_component_connector
// Connected-component labeling over an adjacency bit matrix, with edge output.
// ----------------------------------------------------------------------------
// Usage:
//   Input transactions are taken on start while busy is low. An add-edge
//   command with both endpoints in 1..node_count (node_count clamped to
//   1..MAX_NODES) writes the row store twice and holds busy for one cycle;
//   an out-of-range edge is dropped at once. A finish command runs a
//   breadth-first search through one shared find-first unit and the
//   single-port row store, then strobes the count transaction. The
//   block then emits one edge transaction (1, smallest vertex) per extra
//   component, one per cycle on o_res_valid, last marked, and then
//   clears all MAX_NODES rows before dropping busy.
//   Results are strobed for a single cycle; the receiver cannot stall.
//   Reset runs the same row clear with busy high. node_count is written
//   over the APB port at byte address 0; the user must write it only
//   while busy is low, and the block itself does not enforce this.
// ----------------------------------------------------------------------------
module graph_component_connector (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  gcomp_pkg::t_in_item                 i_item,
    output logic                                o_res_valid,
    output gcomp_pkg::t_out_item                o_res,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [gcomp_pkg::CFG_AW-1:0]        paddr,
    input  logic [gcomp_pkg::CFG_DW-1:0]        pwdata,
    output logic [gcomp_pkg::CFG_DW-1:0]        prdata,
    output logic                                pready
);

    logic [gcomp_pkg::NODE_W-1:0] r_node_count;
    gcomp_pkg::t_ram_req          ram_req;
    gcomp_pkg::t_nodes            ram_rdata;
    logic                         cfg_wr;
    logic                         reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = paddr[gcomp_pkg::CFG_AW-1];
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign prdata  = (reg_sel == gcomp_pkg::REG_NODE_COUNT) ?
                     gcomp_pkg::CFG_DW'(r_node_count) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= gcomp_pkg::NODE_CNT_RST;
        end else if (cfg_wr && (reg_sel == gcomp_pkg::REG_NODE_COUNT)) begin
            r_node_count <= pwdata[gcomp_pkg::NODE_W-1:0];
        end
    end

    gcomp_seq u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_item       (i_item),
        .i_node_count (r_node_count),
        .o_busy       (busy),
        .o_valid      (o_res_valid),
        .o_res        (o_res),
        .o_ram_req    (ram_req),
        .i_ram_rdata  (ram_rdata)
    );

    gcomp_adj_ram u_adj_ram (
        .i_clk   (i_clk),
        .i_req   (ram_req),
        .o_rdata (ram_rdata)
    );

endmodule
